// ----- rtl/dmwc_pkg.sv -----
// Shared types, constants and codes for the direct-mapped write-back cache controller.
package dmwc_pkg;

    localparam int LINES_PER_REGION  = 64;
    localparam int BLOCKS_PER_LINE   = 8;
    localparam int SECTORS_PER_BLOCK = 8;
    localparam int REGION_COUNT      = 2;

    localparam int LINE_SECTORS = BLOCKS_PER_LINE * SECTORS_PER_BLOCK;
    localparam int SLOTS        = REGION_COUNT * LINES_PER_REGION;
    localparam int IDX_W        = $clog2(LINES_PER_REGION);
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int OFF_W        = $clog2(LINE_SECTORS);
    localparam int BLK_SH       = $clog2(SECTORS_PER_BLOCK);
    localparam int LBA_W        = 40;
    localparam int TAG_W        = LBA_W - OFF_W;
    localparam int CNT_W        = 12;
    localparam int PS_W         = 7;
    localparam int MASK_W       = 8;
    localparam int SECTOR_LIMIT = 63 * LINE_SECTORS;

    localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'((1 << BLOCKS_PER_LINE) - 1);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_WHOLE = 2'd1;
    localparam logic [1:0] EV_MERGE = 2'd2;

    localparam logic [1:0] FL_NONE  = 2'd0;
    localparam logic [1:0] FL_WHOLE = 2'd1;
    localparam logic [1:0] FL_MERGE = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ALIGN = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic             region;
        logic [LBA_W-1:0] request_lba;
        logic [CNT_W-1:0] sector_count;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  line_index;
        logic [1:0]        evict_action;
        logic [TAG_W-1:0]  evict_line;
        logic [MASK_W-1:0] evict_mask;
        logic [1:0]        fill_action;
        logic [MASK_W-1:0] fill_mask;
        logic [LBA_W-1:0]  piece_lba;
        logic [PS_W-1:0]   piece_sectors;
        logic              piece_is_write;
        logic              last;
        logic [1:0]        error;
    } t_rsp;

    typedef enum logic [1:0] {
        JOB_RW,
        JOB_FLUSH,
        JOB_ERR
    } t_job_kind;

    typedef struct packed {
        t_job_kind        kind;
        logic             is_write;
        logic             region;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       err;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_ERR,
        S_FSCAN,
        S_FEMIT
    } t_state;

endpackage

// ----- rtl/dmwc_front.sv -----
// Front end: accepts request items, classifies them and queues jobs for the back end.
module dmwc_front import dmwc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_job_pop
);

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    t_job n_job;
    logic n_push;
    logic misaligned;
    logic acc;

    assign o_ready     = (r_count != 2'd2);
    assign acc         = i_valid && o_ready;
    assign misaligned  = (i_req.request_lba[BLK_SH-1:0] != '0);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_job          = '0;
        n_job.is_write = (i_req.command == CMD_WRITE);
        n_job.region   = i_req.region;
        n_job.lba      = i_req.request_lba;
        n_job.cnt      = i_req.sector_count;
        n_job.kind     = JOB_RW;
        n_job.err      = ERR_OK;
        n_push         = 1'b0;
        unique case (i_req.command)
            CMD_FLUSH: begin
                n_job.kind = JOB_FLUSH;
                n_push     = 1'b1;
            end
            CMD_NONE: begin
                n_push = 1'b0;
            end
            default: begin
                if (misaligned) begin
                    n_job.kind = JOB_ERR;
                    n_job.err  = ERR_ALIGN;
                    n_push     = 1'b1;
                end else if (i_req.sector_count == '0) begin
                    n_push = 1'b0;
                end else if (32'(i_req.sector_count) > SECTOR_LIMIT) begin
                    n_job.kind = JOB_ERR;
                    n_job.err  = ERR_LONG;
                    n_push     = 1'b1;
                end else begin
                    n_push = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (acc && n_push) begin
                r_q[r_wp] <= n_job;
                r_wp      <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'((acc && n_push) ? 1 : 0) - 2'(i_job_pop ? 1 : 0);
        end
    end

endmodule

// ----- rtl/dmwc_back.sv -----
// Back end: tag/policy walk per line piece, flush scan, error items, result register.
module dmwc_back import dmwc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic [TAG_W-1:0]  mem_tag  [SLOTS];
    logic [MASK_W-1:0] mem_fill [SLOTS];

    t_state            r_state, n_state;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [SLOTS-1:0]  r_dirty, n_dirty;
    t_job_kind         r_kind, n_kind;
    logic              r_wr, n_wr;
    logic              r_region, n_region;
    logic [LBA_W-1:0]  r_lba, n_lba;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_err, n_err;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [TAG_W-1:0]  r_tag_q;
    logic [MASK_W-1:0] r_fill_q;
    logic              r_out_valid;
    t_rsp              r_out, n_out;
    logic              n_emit;

    logic                 out_free;
    logic [IDX_W-1:0]     rd_idx;
    logic [SLOT_W-1:0]    rd_slot;
    logic                 mem_we;
    logic [MASK_W-1:0]    mem_wfill;
    logic [TAG_W-1:0]     line;
    logic [OFF_W-1:0]     off;
    logic [PS_W-1:0]      room;
    logic [PS_W-1:0]      n_sec;
    logic [3:0]           nb;
    logic [MASK_W-1:0]    pm;
    logic                 v;
    logic                 d;
    logic [MASK_W-1:0]    fv;
    logic                 hit;
    logic                 miss;
    logic [LINES_PER_REGION-1:0] dv_reg;
    logic [LINES_PER_REGION-1:0] above;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;

    assign rd_idx  = (r_kind == JOB_RW) ? r_lba[OFF_W +: IDX_W] : r_idx;
    assign rd_slot = {r_region, rd_idx};

    assign line  = r_lba[LBA_W-1:OFF_W];
    assign off   = r_lba[OFF_W-1:0];
    assign room  = PS_W'(LINE_SECTORS) - PS_W'(off);
    assign n_sec = (r_cnt < CNT_W'(room)) ? PS_W'(r_cnt) : room;
    assign nb    = 4'((n_sec + PS_W'(SECTORS_PER_BLOCK - 1)) >> BLK_SH);
    assign pm    = MASK_W'(((16'd1 << nb) - 16'd1) << off[OFF_W-1:BLK_SH]);
    assign v     = r_valid[rd_slot];
    assign d     = r_dirty[rd_slot];
    assign fv    = v ? r_fill_q : '0;
    assign hit   = v && (r_tag_q == line);
    assign miss  = v && !hit;

    assign dv_reg = r_region ? (r_dirty[SLOTS-1 -: LINES_PER_REGION] &
                                r_valid[SLOTS-1 -: LINES_PER_REGION])
                             : (r_dirty[LINES_PER_REGION-1:0] &
                                r_valid[LINES_PER_REGION-1:0]);
    assign above  = dv_reg & (~LINES_PER_REGION'(0) << ({1'b0, r_idx} + 7'd1));

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_kind    = r_kind;
        n_wr      = r_wr;
        n_region  = r_region;
        n_lba     = r_lba;
        n_cnt     = r_cnt;
        n_err     = r_err;
        n_idx     = r_idx;
        n_out     = '0;
        n_emit    = 1'b0;
        mem_we    = 1'b0;
        mem_wfill = fv;
        o_job_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_kind    = i_job.kind;
                    n_wr      = i_job.is_write;
                    n_region  = i_job.region;
                    n_lba     = i_job.lba;
                    n_cnt     = i_job.cnt;
                    n_err     = i_job.err;
                    n_idx     = '0;
                    unique case (i_job.kind)
                        JOB_RW:    n_state = S_READ;
                        JOB_FLUSH: n_state = S_FSCAN;
                        default:   n_state = S_ERR;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_emit              = 1'b1;
                    n_out.line_index    = line[IDX_W-1:0];
                    n_out.piece_lba     = r_lba;
                    n_out.piece_sectors = n_sec;
                    n_out.piece_is_write = r_wr;
                    if (miss && d) begin
                        n_out.evict_mask   = r_fill_q;
                        n_out.evict_action = (r_fill_q == FULL_MASK) ? EV_WHOLE : EV_MERGE;
                        n_out.evict_line   = r_tag_q;
                        n_dirty[rd_slot]   = 1'b0;
                    end
                    if (r_wr) begin
                        mem_wfill        = miss ? pm : (fv | pm);
                        n_dirty[rd_slot] = 1'b1;
                    end else if (hit) begin
                        if ((pm & ~fv) != '0) begin
                            n_out.fill_action = FL_MERGE;
                            n_out.fill_mask   = fv;
                            mem_wfill         = FULL_MASK;
                        end
                    end else begin
                        n_out.fill_action = FL_WHOLE;
                        mem_wfill         = FULL_MASK;
                        n_dirty[rd_slot]  = 1'b0;
                    end
                    mem_we           = 1'b1;
                    n_valid[rd_slot] = 1'b1;
                    n_cnt            = r_cnt - CNT_W'(n_sec);
                    n_lba            = r_lba + LBA_W'(n_sec);
                    n_out.last       = (n_cnt == '0);
                    n_state          = (n_cnt == '0) ? S_IDLE : S_READ;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_emit      = 1'b1;
                    n_out.last  = 1'b1;
                    n_out.error = r_err;
                    n_state     = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (dv_reg[r_idx]) begin
                    n_state = S_FEMIT;
                end else if (r_idx == IDX_W'(LINES_PER_REGION - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FEMIT: begin
                if (out_free) begin
                    n_emit             = 1'b1;
                    n_out.line_index   = r_idx;
                    n_out.evict_mask   = r_fill_q;
                    n_out.evict_action = (r_fill_q == FULL_MASK) ? EV_WHOLE : EV_MERGE;
                    n_out.evict_line   = r_tag_q;
                    n_out.last         = (above == '0);
                    n_dirty[rd_slot]   = 1'b0;
                    if (r_idx == IDX_W'(LINES_PER_REGION - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_FSCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tag[rd_slot]  <= line;
            mem_fill[rd_slot] <= mem_wfill;
        end
        r_tag_q  <= mem_tag[rd_slot];
        r_fill_q <= mem_fill[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
            r_kind      <= JOB_RW;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_kind  <= n_kind;
            r_idx   <= n_idx;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr     <= n_wr;
        r_region <= n_region;
        r_lba    <= n_lba;
        r_cnt    <= n_cnt;
        r_err    <= n_err;
        if (n_emit) begin
            r_out <= n_out;
        end
    end

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("piece walk with no sectors left");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error != ERR_OK)) |-> r_out.last)
        else $error("error item not marked last");

    a_merge_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.fill_action != FL_NONE)) |-> !r_out.piece_is_write)
        else $error("fill issued for a write piece");

    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_dirty & ~r_valid) == '0))
        else $error("dirty line not valid");

    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_valid == '0 && !r_out_valid))
        else $error("state not cleared by reset");

endmodule

// ----- rtl/direct_mapped_writeback_cache_ctrl.sv -----
// Top level: direct-mapped write-back sector cache tag and policy controller.
//  channel   | valid   | ready   | payload
//  request   | i_valid | o_ready | i_req (t_req)
//  result    | o_valid | i_ready | o_rsp (t_rsp)
// A read/write piece goes through S_READ (tag RAM read), then S_EMIT (update and result).
// S_EMIT, like S_ERR and S_FEMIT, waits while the result register is full.
// A flush scans the region's 64 lines: S_FSCAN steps over clean lines, S_FEMIT emits each dirty one.
// Synchronous reset clears valid and dirty bits; tag/fill RAMs need no clearing.
// A two-item job queue lets requests be taken while the result side stalls.
module direct_mapped_writeback_cache_ctrl import dmwc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic job_valid;
    t_job job;
    logic job_pop;

    dmwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    dmwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- tb/sv/tb_direct_mapped_writeback_cache_ctrl.sv -----
// Regression for the cache tag and policy controller: directed, random and back-pressure requests, checked per piece.
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache_ctrl;
    import dmwc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;

    direct_mapped_writeback_cache_ctrl i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // shadow tag store
    logic             sh_valid [SLOTS];
    logic [TAG_W-1:0] sh_tag   [SLOTS];
    logic [MASK_W-1:0] sh_fill [SLOTS];
    logic             sh_dirty [SLOTS];

    t_rsp pending_pieces[$];
    int   n_errors = 0;
    int   n_items = 0;
    int   n_results = 0;
    int   n_evicts = 0;
    int   cycles = 0;
    int   hold_cycles = 0;
    bit   sink_random = 1'b1;

    task automatic report(input string what, input t_rsp got, input t_rsp want);
        n_errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic t_rsp mk_rsp(input logic [IDX_W-1:0] li, input logic [1:0] ea,
                                    input logic [TAG_W-1:0] el, input logic [MASK_W-1:0] em,
                                    input logic [1:0] fa, input logic [MASK_W-1:0] fm,
                                    input logic [LBA_W-1:0] plba, input logic [PS_W-1:0] ps,
                                    input logic wr, input logic lst, input logic [1:0] err);
        t_rsp r;
        r.line_index = li; r.evict_action = ea; r.evict_line = el; r.evict_mask = em;
        r.fill_action = fa; r.fill_mask = fm; r.piece_lba = plba; r.piece_sectors = ps;
        r.piece_is_write = wr; r.last = lst; r.error = err;
        return r;
    endfunction

    task automatic predict_request(input t_req rq);
        logic [LBA_W-1:0] lba;
        int cnt, off, n, b, nb, s, last_dirty;
        logic [TAG_W-1:0] line;
        logic [IDX_W-1:0] idx;
        logic [MASK_W-1:0] pm, em, fm;
        logic [1:0] ea, fa;
        logic [TAG_W-1:0] el;
        logic hit, miss;
        lba = rq.request_lba;
        cnt = rq.sector_count;
        if (rq.command == CMD_NONE) return;
        if (rq.command == CMD_FLUSH) begin
            last_dirty = -1;
            for (int i = 0; i < LINES_PER_REGION; i++) begin
                s = rq.region * LINES_PER_REGION + i;
                if (sh_dirty[s] && sh_valid[s]) last_dirty = i;
            end
            for (int i = 0; i < LINES_PER_REGION; i++) begin
                s = rq.region * LINES_PER_REGION + i;
                if (sh_dirty[s] && sh_valid[s]) begin
                    pending_pieces.push_back(mk_rsp(IDX_W'(i),
                        sh_fill[s] == FULL_MASK ? EV_WHOLE : EV_MERGE, sh_tag[s],
                        sh_fill[s], FL_NONE, '0, '0, '0, 1'b0, i == last_dirty, ERR_OK));
                    sh_dirty[s] = 1'b0;
                end
            end
            return;
        end
        if (lba[BLK_SH-1:0] != 0) begin
            pending_pieces.push_back(mk_rsp('0, EV_NONE, '0, '0, FL_NONE, '0, '0, '0,
                                            1'b0, 1'b1, ERR_ALIGN));
            return;
        end
        if (cnt == 0) return;
        if (cnt > SECTOR_LIMIT) begin
            pending_pieces.push_back(mk_rsp('0, EV_NONE, '0, '0, FL_NONE, '0, '0, '0,
                                            1'b0, 1'b1, ERR_LONG));
            return;
        end
        while (cnt > 0) begin
            off = lba[OFF_W-1:0];
            n = LINE_SECTORS - off;
            if (n > cnt) n = cnt;
            line = lba[LBA_W-1:OFF_W];
            idx = line[IDX_W-1:0];
            s = rq.region * LINES_PER_REGION + idx;
            b = off / SECTORS_PER_BLOCK;
            nb = (n + SECTORS_PER_BLOCK - 1) / SECTORS_PER_BLOCK;
            pm = '0;
            for (int i = 0; i < nb && b + i < BLOCKS_PER_LINE; i++) pm[b + i] = 1'b1;
            hit = sh_valid[s] && sh_tag[s] == line;
            miss = sh_valid[s] && !hit;
            ea = EV_NONE; el = '0; em = '0; fa = FL_NONE; fm = '0;
            if (miss && sh_dirty[s]) begin
                em = sh_fill[s];
                ea = em == FULL_MASK ? EV_WHOLE : EV_MERGE;
                el = sh_tag[s];
                sh_dirty[s] = 1'b0;
            end
            if (rq.command == CMD_WRITE) begin
                sh_fill[s] = miss ? pm : (sh_fill[s] | pm);
                sh_dirty[s] = 1'b1;
            end else if (hit) begin
                if ((pm & ~sh_fill[s]) != 0) begin
                    fa = FL_MERGE;
                    fm = sh_fill[s];
                    sh_fill[s] = FULL_MASK;
                end
            end else begin
                fa = FL_WHOLE;
                sh_fill[s] = FULL_MASK;
                sh_dirty[s] = 1'b0;
            end
            sh_valid[s] = 1'b1;
            sh_tag[s] = line;
            cnt -= n;
            pending_pieces.push_back(mk_rsp(idx, ea, el, em, fa, fm, lba, PS_W'(n),
                                            rq.command == CMD_WRITE, cnt == 0, ERR_OK));
            lba = lba + LBA_W'(n);
        end
    endtask

    // result checker and receiver idling
    always @(posedge i_clk) begin
        t_rsp want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_pieces.size() == 0) begin
                report("unexpected item", o_rsp, '0);
            end else begin
                want = pending_pieces.pop_front();
                if (want.evict_action != EV_NONE) n_evicts++;
                if (o_rsp.line_index != want.line_index) report("line_index", o_rsp, want);
                if (o_rsp.evict_action != want.evict_action) report("evict_action", o_rsp, want);
                if (o_rsp.evict_line != want.evict_line) report("evict_line", o_rsp, want);
                if (o_rsp.evict_mask != want.evict_mask) report("evict_mask", o_rsp, want);
                if (o_rsp.fill_action != want.fill_action) report("fill_action", o_rsp, want);
                if (o_rsp.fill_mask != want.fill_mask) report("fill_mask", o_rsp, want);
                if (o_rsp.piece_lba != want.piece_lba) report("piece_lba", o_rsp, want);
                if (o_rsp.piece_sectors != want.piece_sectors)
                    report("piece_sectors", o_rsp, want);
                if (o_rsp.piece_is_write != want.piece_is_write)
                    report("piece_is_write", o_rsp, want);
                if (o_rsp.last != want.last) report("last", o_rsp, want);
                if (o_rsp.error != want.error) report("error", o_rsp, want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else if (!sink_random) begin
            i_ready <= 1'b1;
        end else if (i_ready && o_valid) begin
            if ($urandom_range(3) == 0) begin
                i_ready <= 1'b0;
                hold_cycles <= $urandom_range(16);
            end
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 2000000) begin
            $display("timeout");
            $display("direct_mapped_writeback_cache_ctrl regression: fail");
            $finish;
        end
    end

    bit src_random = 1'b1;

    // valid stays high after an accept so a following item can go back to back
    task automatic send_item(input t_req rq);
        int gap;
        gap = src_random ? ($urandom_range(3) == 0 ? $urandom_range(16) : 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_request(rq);
        n_items++;
    endtask

    task automatic send_cmd(input logic [1:0] c, input logic rg, input logic [LBA_W-1:0] lba,
                            input logic [CNT_W-1:0] cnt);
        t_req rq;
        rq.command = c; rq.region = rg; rq.request_lba = lba; rq.sector_count = cnt;
        send_item(rq);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic test_directed;
        send_cmd(CMD_READ, 1'b0, 40'd0, 12'd64);
        send_cmd(CMD_READ, 1'b0, 40'd0, 12'd8);
        send_cmd(CMD_WRITE, 1'b0, 40'd64, 12'd8);
        send_cmd(CMD_WRITE, 1'b0, 40'd64 + 40'd4096, 12'd16);
        send_cmd(CMD_READ, 1'b0, 40'd64 + 40'd4096, 12'd64);
        send_cmd(CMD_WRITE, 1'b1, 40'd128, 12'd64);
        send_cmd(CMD_WRITE, 1'b1, 40'd128 + 40'd4096, 12'd1);
        send_cmd(CMD_READ, 1'b1, 40'd3, 12'd0);
        send_cmd(CMD_READ, 1'b0, 40'd8, 12'd0);
        send_cmd(CMD_WRITE, 1'b0, 40'd8, 12'd4032);
        send_cmd(CMD_WRITE, 1'b0, 40'd8, 12'd4033);
        send_cmd(CMD_READ, 1'b1, 40'd16, 12'hFFF);
        send_cmd(CMD_NONE, 1'b0, 40'd5, 12'd10);
        send_cmd(CMD_WRITE, 1'b1, 40'hFF_FFFF_FFF8, 12'd24);
        send_cmd(CMD_READ, 1'b0, 40'hFF_FFFF_FFC0, 12'd200);
        send_cmd(CMD_FLUSH, 1'b0, 40'h55, 12'd7);
        send_cmd(CMD_FLUSH, 1'b1, 40'd0, 12'd0);
        send_cmd(CMD_FLUSH, 1'b1, 40'd0, 12'd0);
        send_cmd(CMD_WRITE, 1'b0, 40'hAA_AAAA_AAA8, 12'd1000);
        send_cmd(CMD_READ, 1'b0, 40'h55_5555_5540, 12'd3000);
        drain();
    endtask

    function automatic t_req rand_req;
        t_req rq;
        logic [TAG_W-1:0] line;
        int k;
        k = $urandom_range(99);
        rq.region = 1'($urandom_range(1));
        // few distinct tags per slot so hits and conflicts both happen
        line = (TAG_W'($urandom_range(3)) << IDX_W) | TAG_W'($urandom_range(7));
        if (k < 3) line = TAG_W'({$urandom, $urandom});
        rq.request_lba = {line, OFF_W'($urandom_range(BLOCKS_PER_LINE - 1) * SECTORS_PER_BLOCK)};
        rq.command = k < 45 ? CMD_WRITE : (k < 85 ? CMD_READ : (k < 92 ? CMD_FLUSH : CMD_NONE));
        rq.sector_count = $urandom_range(4) == 0 ? CNT_W'($urandom_range(400))
                                                 : CNT_W'($urandom_range(1, 70));
        if (k >= 95) rq.request_lba[BLK_SH-1:0] = BLK_SH'($urandom_range(1, 7));
        if (k == 94) rq.sector_count = CNT_W'($urandom_range(SECTOR_LIMIT + 1, 4095));
        if (k == 93) rq.sector_count = CNT_W'($urandom_range(3000, SECTOR_LIMIT));
        return rq;
    endfunction

    task automatic test_random;
        for (int i = 0; i < 260; i++) begin
            send_item(rand_req());
            if (i % 64 == 63) drain();
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_cycles = 400;
        src_random = 1'b0;
        for (int i = 0; i < 20; i++) send_item(rand_req());
        src_random = 1'b1;
        drain();
        sink_random = 1'b0;
        for (int i = 0; i < 20; i++) send_item(rand_req());
        drain();
        sink_random = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            sh_valid[i] = 1'b0; sh_tag[i] = '0; sh_fill[i] = '0; sh_dirty[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        $display("sent %0d requests, checked %0d results (%0d with write-back)",
                 n_items, n_results, n_evicts);
        if (n_errors == 0) begin
            $display("direct_mapped_writeback_cache_ctrl regression: pass");
        end else begin
            $display("direct_mapped_writeback_cache_ctrl regression: fail");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/dmwc_pkg.sv
rtl/dmwc_front.sv
rtl/dmwc_back.sv
rtl/direct_mapped_writeback_cache_ctrl.sv
tb/sv/tb_direct_mapped_writeback_cache_ctrl.sv
